FILE: sv/bdgp_pkg.sv
`timescale 1ns / 1ps

package bdgp_pkg;

  // Percent scale and the fixed colour used in low-power mode.
  localparam int unsigned PCT_FULL      = 100;
  localparam int unsigned LOW_POWER_CAP = 25;
  localparam int unsigned LOW_POWER_RED = 255;

  // Division by 100 as a multiply by a reciprocal: floor(x / 100) equals
  // (x * 5243) >> 19 for every x below 43690, which covers all products here.
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam int unsigned PIXELS_PER_BYTE = 8;
  localparam int unsigned PIX_IDX_W       = $clog2(PIXELS_PER_BYTE);

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned WORD_W  = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Default depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_RED        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIMMING    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_MODE = 3'd5;

  // Power modes; the unused code behaves as normal mode.
  localparam logic [MODE_W-1:0] MODE_NORMAL    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOW_POWER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUSPEND   = 2'd2;

  typedef struct packed {
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic [PCT_W-1:0]   brightness_pct;
    logic [PCT_W-1:0]   dimming_pct;
    logic [MODE_W-1:0]  power_mode;
  } cfg_t;

  // One classified byte waiting for serialization.
  typedef struct packed {
    logic [7:0]        pixel_byte;
    logic              final_byte;
    logic [WORD_W-1:0] grb_word;
  } pix_entry_t;

endpackage

FILE: sv/bitmap_to_dimmed_grb_pixels_top.sv
`timescale 1ns / 1ps

// Turns a stream of pixel-map bytes into 24-bit GRB colour words, eight words
// per byte, first pixel from bit 0. A lit pixel gets the string colour scaled
// by the effective brightness brightness*(100-dimming)/100 (at least 1 when
// brightness is nonzero, capped at 25 and forced to pure red in low-power mode);
// a dark pixel gets zero. In suspend mode bytes are taken and dropped. A byte
// passes a three-stage arithmetic front end, waits in a small queue, and a
// serializer emits one word per cycle while the output is ready, eight words
// per byte; new bytes are taken while earlier ones are serialized, as long as
// the queue has room. The first word of a byte passes the front-end stages,
// the queue and the output register before it is offered. Write the
// configuration registers only while no request is in flight.
module bitmap_to_dimmed_grb_pixels_top #(
  parameter int unsigned QUEUE_DEPTH = bdgp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input requests.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] pixel_byte
  input  logic                              s_axis_tlast,  // final_byte
  // Output requests.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bdgp_pkg::WORD_W-1:0]       m_axis_tdata,  // [23:0] grb_word
  output logic                              m_axis_tlast,  // last_of_byte
  output logic                              m_axis_tuser,  // [0] frame_end
  // Configuration writes.
  input  logic                              cfg_we,
  input  logic [bdgp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdgp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  bdgp_pkg::cfg_t       cfg;
  logic                 accept;
  logic                 push;
  bdgp_pkg::pix_entry_t push_entry;
  logic [1:0]           inflight;
  bdgp_pkg::pix_entry_t head;
  logic                 empty;
  logic [CW-1:0]        q_count;
  logic                 pop;
  logic [CW:0]          occupancy;

  // Configuration registers. Unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_level      <= '0;
      cfg.green_level    <= '0;
      cfg.blue_level     <= '0;
      cfg.brightness_pct <= bdgp_pkg::PCT_W'(bdgp_pkg::PCT_FULL);
      cfg.dimming_pct    <= '0;
      cfg.power_mode     <= bdgp_pkg::MODE_NORMAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdgp_pkg::REG_RED:        cfg.red_level      <= cfg_data;
        bdgp_pkg::REG_GREEN:      cfg.green_level    <= cfg_data;
        bdgp_pkg::REG_BLUE:       cfg.blue_level     <= cfg_data;
        bdgp_pkg::REG_BRIGHTNESS: cfg.brightness_pct <= cfg_data[bdgp_pkg::PCT_W-1:0];
        bdgp_pkg::REG_DIMMING:    cfg.dimming_pct    <= cfg_data[bdgp_pkg::PCT_W-1:0];
        bdgp_pkg::REG_POWER_MODE: cfg.power_mode     <= cfg_data[bdgp_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // A byte is taken only when the queue has room for it and for every byte
  // still in the front end, so the front end never has to stall.
  assign occupancy     = (CW + 1)'(q_count) + (CW + 1)'(inflight);
  assign s_axis_tready = (occupancy < (CW + 1)'(QUEUE_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;

  bdgp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .pixel_byte (s_axis_tdata),
    .final_byte (s_axis_tlast),
    .cfg        (cfg),
    .push       (push),
    .push_entry (push_entry),
    .inflight   (inflight)
  );

  bdgp_queue #(
    .DEPTH (QUEUE_DEPTH),
    .CW    (CW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .count      (q_count)
  );

  bdgp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

FILE: sv/bdgp_front.sv
`timescale 1ns / 1ps

module bdgp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           pixel_byte,
  input  logic                 final_byte,
  input  bdgp_pkg::cfg_t       cfg,
  output logic                 push,
  output bdgp_pkg::pix_entry_t push_entry,
  output logic [1:0]           inflight
);

  localparam int unsigned PROD_W  = 2 * bdgp_pkg::PCT_W;
  localparam int unsigned RMUL1_W = PROD_W + 13;
  localparam int unsigned CH_W    = bdgp_pkg::LEVEL_W + bdgp_pkg::PCT_W;
  localparam int unsigned RMUL2_W = CH_W + 13;

  logic [bdgp_pkg::PCT_W-1:0] bright_sat;
  logic [bdgp_pkg::PCT_W-1:0] dim_sat;
  logic                       low_mode;

  // Stage 1: brightness times the remaining percent.
  logic                       v1;
  logic [7:0]                 pix1;
  logic                       fin1;
  logic [PROD_W-1:0]          prod1;
  logic                       bnz1;
  logic                       low1;

  // Stage 2: effective brightness.
  logic                       v2;
  logic [7:0]                 pix2;
  logic                       fin2;
  logic [bdgp_pkg::PCT_W-1:0] eff2;
  logic                       low2;
  logic [RMUL1_W-1:0]         eff_mul;
  logic [bdgp_pkg::PCT_W-1:0] eff_raw;
  logic [bdgp_pkg::PCT_W-1:0] eff_next;

  // Stage 3: each channel times the effective brightness.
  logic                       v3;
  logic [7:0]                 pix3;
  logic                       fin3;
  logic [CH_W-1:0]            g3;
  logic [CH_W-1:0]            r3;
  logic [CH_W-1:0]            b3;
  logic [bdgp_pkg::LEVEL_W-1:0] g_src;
  logic [bdgp_pkg::LEVEL_W-1:0] r_src;
  logic [bdgp_pkg::LEVEL_W-1:0] b_src;
  logic [RMUL2_W-1:0]         g_mul;
  logic [RMUL2_W-1:0]         r_mul;
  logic [RMUL2_W-1:0]         b_mul;

  assign bright_sat = (cfg.brightness_pct > bdgp_pkg::PCT_W'(bdgp_pkg::PCT_FULL))
                      ? bdgp_pkg::PCT_W'(bdgp_pkg::PCT_FULL) : cfg.brightness_pct;
  assign dim_sat    = (cfg.dimming_pct > bdgp_pkg::PCT_W'(bdgp_pkg::PCT_FULL))
                      ? bdgp_pkg::PCT_W'(bdgp_pkg::PCT_FULL) : cfg.dimming_pct;
  assign low_mode   = (cfg.power_mode == bdgp_pkg::MODE_LOW_POWER);

  // Suspended bytes never enter the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept && (cfg.power_mode != bdgp_pkg::MODE_SUSPEND);
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    pix1  <= pixel_byte;
    fin1  <= final_byte;
    prod1 <= PROD_W'(bright_sat) *
             PROD_W'(bdgp_pkg::PCT_W'(bdgp_pkg::PCT_FULL) - dim_sat);
    bnz1  <= (bright_sat != '0);
    low1  <= low_mode;
  end

  always_comb begin
    eff_mul  = RMUL1_W'(prod1) * RMUL1_W'(bdgp_pkg::RECIP_100);
    eff_raw  = eff_mul[bdgp_pkg::RECIP_SHIFT +: bdgp_pkg::PCT_W];
    eff_next = eff_raw;
    if (bnz1 && (eff_raw == '0)) begin
      eff_next = bdgp_pkg::PCT_W'(1);
    end
    if (low1 && (eff_next > bdgp_pkg::PCT_W'(bdgp_pkg::LOW_POWER_CAP))) begin
      eff_next = bdgp_pkg::PCT_W'(bdgp_pkg::LOW_POWER_CAP);
    end
  end

  always_ff @(posedge clk) begin
    pix2 <= pix1;
    fin2 <= fin1;
    eff2 <= eff_next;
    low2 <= low1;
  end

  // Low-power mode forces the colour to pure red.
  assign g_src = low2 ? '0 : cfg.green_level;
  assign r_src = low2 ? bdgp_pkg::LEVEL_W'(bdgp_pkg::LOW_POWER_RED) : cfg.red_level;
  assign b_src = low2 ? '0 : cfg.blue_level;

  always_ff @(posedge clk) begin
    pix3 <= pix2;
    fin3 <= fin2;
    g3   <= CH_W'(g_src) * CH_W'(eff2);
    r3   <= CH_W'(r_src) * CH_W'(eff2);
    b3   <= CH_W'(b_src) * CH_W'(eff2);
  end

  assign g_mul = RMUL2_W'(g3) * RMUL2_W'(bdgp_pkg::RECIP_100);
  assign r_mul = RMUL2_W'(r3) * RMUL2_W'(bdgp_pkg::RECIP_100);
  assign b_mul = RMUL2_W'(b3) * RMUL2_W'(bdgp_pkg::RECIP_100);

  assign push                  = v3;
  assign push_entry.pixel_byte = pix3;
  assign push_entry.final_byte = fin3;
  assign push_entry.grb_word   = {g_mul[bdgp_pkg::RECIP_SHIFT +: bdgp_pkg::LEVEL_W],
                                  r_mul[bdgp_pkg::RECIP_SHIFT +: bdgp_pkg::LEVEL_W],
                                  b_mul[bdgp_pkg::RECIP_SHIFT +: bdgp_pkg::LEVEL_W]};

  assign inflight = 2'(v1) + 2'(v2) + 2'(v3);

endmodule

FILE: sv/bdgp_queue.sv
`timescale 1ns / 1ps

module bdgp_queue #(
  parameter int unsigned DEPTH = bdgp_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bdgp_pkg::pix_entry_t push_entry,
  input  logic                 pop,
  output bdgp_pkg::pix_entry_t head,
  output logic                 empty,
  output logic [CW-1:0]        count
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bdgp_pkg::pix_entry_t slots [DEPTH];
  logic [AW-1:0]        wr_ptr;
  logic [AW-1:0]        rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);

endmodule

FILE: sv/bdgp_back.sv
`timescale 1ns / 1ps

module bdgp_back (
  input  logic                         clk,
  input  logic                         rst,
  input  bdgp_pkg::pix_entry_t         head,
  input  logic                         empty,
  output logic                         pop,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [bdgp_pkg::WORD_W-1:0]  m_axis_tdata,
  output logic                         m_axis_tlast,
  output logic                         m_axis_tuser
);

  localparam logic [bdgp_pkg::PIX_IDX_W-1:0] LAST_IDX =
    bdgp_pkg::PIX_IDX_W'(bdgp_pkg::PIXELS_PER_BYTE - 1);

  logic                           load;
  logic [bdgp_pkg::PIX_IDX_W-1:0] idx;
  logic                           at_last;

  assign load    = !empty && (!m_axis_tvalid || m_axis_tready);
  assign at_last = (idx == LAST_IDX);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      idx           <= '0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
      idx           <= at_last ? '0 : idx + bdgp_pkg::PIX_IDX_W'(1);
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= head.pixel_byte[idx] ? head.grb_word : '0;
      m_axis_tlast <= at_last;
      m_axis_tuser <= at_last && head.final_byte;
    end
  end

endmodule

FILE: sv/bdgp_checker.sv
`timescale 1ns / 1ps

module bdgp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [bdgp_pkg::WORD_W-1:0] m_axis_tdata,
  input logic                        m_axis_tlast,
  input logic                        m_axis_tuser
);

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A frame can only end on the eighth pixel of a byte.
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!m_axis_tuser || m_axis_tlast))
    else $error("frame end away from the last pixel of a byte");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
       && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // Input back-pressure only comes from queued work, which reaches the output.
  a_busy_output: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |=> m_axis_tvalid)
    else $error("input stalled while output is idle");

endmodule

bind bitmap_to_dimmed_grb_pixels_top bdgp_checker u_bdgp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: bench/bitmap_to_dimmed_grb_pixels_top_tb.sv
`timescale 1ns / 1ps

module bitmap_to_dimmed_grb_pixels_top_tb;
  import bdgp_pkg::*;

  // Register indexes past the last real register; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  // The spare power-mode code, which the block treats as normal mode.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Cycles to let pass after the last expected word before touching the
  // registers. A byte goes through the front-end stages and the queue to the
  // output well within this, so a byte dropped in suspend mode is long gone.
  localparam int SETTLE_CYCLES = 16;
  // Length of the long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES = 150;
  // Hard stop for the whole run, with ample margin over the slowest correct run.
  localparam int CYCLE_LIMIT = 200000;
  // Random bytes per configuration in the random part.
  localparam int BYTES_PER_SETTING = 20;

  typedef struct {
    logic [WORD_W-1:0] grb;
    logic              last;
    logic              fend;
  } pixel_result_t;

  // Tracks the register file and the pixel words still owed by the block.
  class pixel_word_tracker;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [PCT_W-1:0]   bright;
    logic [PCT_W-1:0]   dim;
    logic [MODE_W-1:0]  mode;
    pixel_result_t      pending_words[$];
    int                 mismatches;
    int                 words_checked;

    function new();
      red           = '0;
      green         = '0;
      blue          = '0;
      bright        = PCT_W'(PCT_FULL);
      dim           = '0;
      mode          = MODE_NORMAL;
      mismatches    = 0;
      words_checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_RED:        red    = data[LEVEL_W-1:0];
        REG_GREEN:      green  = data[LEVEL_W-1:0];
        REG_BLUE:       blue   = data[LEVEL_W-1:0];
        REG_BRIGHTNESS: bright = data[PCT_W-1:0];
        REG_DIMMING:    dim    = data[PCT_W-1:0];
        REG_POWER_MODE: mode   = data[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_pct(logic [PCT_W-1:0] p);
      return (p > PCT_FULL) ? PCT_FULL : int'(p);
    endfunction

    // Color word for a lit pixel under the current settings.
    function logic [WORD_W-1:0] lit_word();
      int unsigned b;
      int unsigned d;
      int unsigned e;
      logic [7:0]  g_ch;
      logic [7:0]  r_ch;
      logic [7:0]  b_ch;
      b = clamp_pct(bright);
      d = clamp_pct(dim);
      e = b * (PCT_FULL - d) / PCT_FULL;
      if (b > 0 && e < 1) e = 1;
      if (mode == MODE_LOW_POWER && e > LOW_POWER_CAP) e = LOW_POWER_CAP;
      if (mode == MODE_LOW_POWER) begin
        g_ch = '0;
        r_ch = 8'(LOW_POWER_RED * e / PCT_FULL);
        b_ch = '0;
      end else begin
        g_ch = 8'(green * e / PCT_FULL);
        r_ch = 8'(red * e / PCT_FULL);
        b_ch = 8'(blue * e / PCT_FULL);
      end
      return {g_ch, r_ch, b_ch};
    endfunction

    // Records an accepted byte and returns how many words it is owed.
    function int note_byte(logic [7:0] px, logic fin);
      logic [WORD_W-1:0] word;
      pixel_result_t     res;
      if (mode == MODE_SUSPEND) return 0;
      word = lit_word();
      for (int i = 0; i < PIXELS_PER_BYTE; i++) begin
        res.grb  = px[i] ? word : '0;
        res.last = (i == PIXELS_PER_BYTE - 1);
        res.fend = res.last && fin;
        pending_words.push_back(res);
      end
      return PIXELS_PER_BYTE;
    endfunction

    function void check_pixel(logic [WORD_W-1:0] grb, logic last, logic fend);
      pixel_result_t want;
      words_checked++;
      if (pending_words.size() == 0) begin
        $error("unexpected pixel word %h (last_of_byte %b, frame_end %b)", grb, last, fend);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      if (grb !== want.grb) begin
        $error("grb_word: expected %h, got %h", want.grb, grb);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_of_byte: expected %b, got %b", want.last, last);
        mismatches++;
      end
      if (fend !== want.fend) begin
        $error("frame_end: expected %b, got %b", want.fend, fend);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [WORD_W-1:0]     m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pixel_word_tracker tracker = new();

  // Idle mix of the current phase, in percent of cycles.
  int gap_pct   = 0;
  int stall_pct = 0;
  // The main thread raises hold_req; the receiver process owns the count.
  bit hold_req  = 1'b0;
  int hold_left = 0;

  int cycle_count   = 0;
  int counted_bytes = 0;
  int dropped_bytes = 0;
  int settings_used = 0;

  bitmap_to_dimmed_grb_pixels_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Guard against a hung block or a word that never shows up.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed",
               cycle_count, tracker.pending_words.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver side. Every word taken at this edge is checked against the oldest
  // one owed, then tready for the next cycle is chosen. A pending hold-off
  // request turns into a long run of cycles with tready low, counted here.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      tracker.check_pixel(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // One register write, then the enable drops on the following cycle.
  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               input logic [7:0] bri, input logic [7:0] dimv,
                               input logic [7:0] mode);
    apply_reg(REG_RED, r);
    apply_reg(REG_GREEN, g);
    apply_reg(REG_BLUE, b);
    apply_reg(REG_BRIGHTNESS, bri);
    apply_reg(REG_DIMMING, dimv);
    apply_reg(REG_POWER_MODE, mode);
    settings_used++;
  endtask

  // Offers one byte, with random idle cycles in front of it, and returns once
  // the block has taken it. tvalid stays high so the next byte can follow.
  task automatic send_byte(input logic [7:0] px, input logic fin);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    if (tracker.note_byte(px, fin) > 0) counted_bytes++;
    else dropped_bytes++;
  endtask

  task automatic park_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every owed word has come back, then lets the block settle.
  task automatic wait_idle();
    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A frame of n random bytes with the final flag on the last one. Now and
  // then the flag is scattered at random instead, as a malformed frame.
  task automatic send_frame(input int n);
    bit loose;
    loose = ($urandom_range(7) == 0);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom_range(255)), loose ? 1'($urandom_range(1)) : (i == n - 1));
  endtask

  // Random register set. Brightness and dimming mostly stay within 0..100,
  // but sometimes get a full byte so the masked and saturated cases show up.
  task automatic random_settings();
    logic [7:0] bri;
    logic [7:0] dimv;
    logic [7:0] mode;
    int         pick;
    bri  = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(100));
    dimv = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(100));
    pick = $urandom_range(9);
    if (pick < 6)       mode = {6'($urandom_range(63)) & 6'd0, MODE_NORMAL};
    else if (pick < 8)  mode = {6'd0, MODE_LOW_POWER};
    else if (pick == 8) mode = {6'd0, MODE_UNUSED};
    else                mode = {6'd0, MODE_SUSPEND};
    // The upper bits of the mode write are don't-care to the block.
    mode[7:2] = 6'($urandom_range(63));
    load_settings(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                  bri, dimv, mode);
  endtask

  initial begin
    int sent_before;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Reset values first: black string color at full brightness.
    send_byte(8'hFF, 1'b1);
    park_sender();
    wait_idle();

    // All-dark, all-lit, single-bit and mixed byte patterns and both states of the final flag.
    load_settings(8'hFF, 8'h80, 8'h01, 8'd100, 8'd0, {6'd0, MODE_NORMAL});
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hA5, 1'b1);
    park_sender();
    wait_idle();

    // Zero brightness gives black even for lit pixels.
    apply_reg(REG_BRIGHTNESS, 8'd0);
    send_byte(8'hFF, 1'b1);
    park_sender();
    wait_idle();

    // Brightness 1 dimmed by 99 percent rounds to zero and is floored at 1.
    apply_reg(REG_BRIGHTNESS, 8'd1);
    apply_reg(REG_DIMMING, 8'd99);
    send_byte(8'hFF, 1'b0);
    park_sender();
    wait_idle();

    // Percent values above 100 saturate; a full byte write is cut to 7 bits.
    apply_reg(REG_BRIGHTNESS, 8'hFF);
    apply_reg(REG_DIMMING, 8'd120);
    send_byte(8'h3C, 1'b1);
    park_sender();
    wait_idle();
    apply_reg(REG_DIMMING, 8'd0);
    send_byte(8'hC3, 1'b0);
    park_sender();
    wait_idle();

    // Low-power mode: pure red, brightness capped at 25, and below the cap.
    load_settings(8'h10, 8'hF0, 8'h77, 8'd100, 8'd50, {6'd0, MODE_LOW_POWER});
    send_byte(8'hFF, 1'b1);
    park_sender();
    wait_idle();
    apply_reg(REG_BRIGHTNESS, 8'd20);
    apply_reg(REG_DIMMING, 8'd0);
    send_byte(8'h5A, 1'b0);
    park_sender();
    wait_idle();

    // The spare mode code acts like normal mode.
    load_settings(8'hC8, 8'h64, 8'hFF, 8'd73, 8'd37, {6'd0, MODE_UNUSED});
    send_byte(8'h96, 1'b0);
    send_byte(8'h69, 1'b1);
    park_sender();
    wait_idle();

    // Writes past the last register must leave every setting alone.
    apply_reg(REG_UNUSED_LO, 8'hFF);
    apply_reg(REG_UNUSED_HI, 8'h00);
    send_byte(8'hFF, 1'b1);
    park_sender();
    wait_idle();

    // Suspend mode takes bytes and drops them.
    apply_reg(REG_POWER_MODE, {6'd0, MODE_SUSPEND});
    send_byte(8'hFF, 1'b1);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b1);
    park_sender();
    wait_idle();
    apply_reg(REG_POWER_MODE, {6'd0, MODE_NORMAL});
    send_byte(8'hE7, 1'b1);
    park_sender();
    wait_idle();

    // Random part, in four idle mixes.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 64;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 64;
        end
        default: begin
          gap_pct   = 9;
          stall_pct = 9;
        end
      endcase

      if (ph == 0) begin
        // Hold the receiver off while bytes keep coming, so the queue fills
        // and the block has to push back on its input.
        load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'd100, 8'd0, {6'd0, MODE_NORMAL});
        hold_req = 1'b1;
        for (int k = 0; k < 14; k++)
          send_byte(8'($urandom_range(255)), k == 13);
        park_sender();
        wait_idle();
      end

      for (int k = 0; k < 3; k++) begin
        random_settings();
        if (tracker.mode == MODE_SUSPEND) begin
          for (int j = 0; j < 4; j++)
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        end else begin
          sent_before = counted_bytes;
          while (counted_bytes - sent_before < BYTES_PER_SETTING)
            send_frame($urandom_range(1, 6));
        end
        park_sender();
        wait_idle();
      end
    end

    $display("Sent %0d pixel bytes under %0d register settings, %0d more dropped in suspend;",
             counted_bytes, settings_used, dropped_bytes);
    $display("checked %0d pixel words across four idle mixes and one long output hold-off.",
             tracker.words_checked);
    if (tracker.mismatches == 0 && tracker.pending_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: bitmap_to_dimmed_grb_pixels_top.f
sv/bdgp_pkg.sv
sv/bdgp_front.sv
sv/bdgp_queue.sv
sv/bdgp_back.sv
sv/bitmap_to_dimmed_grb_pixels_top.sv
sv/bdgp_checker.sv
bench/bitmap_to_dimmed_grb_pixels_top_tb.sv
